// File: rtl/rank_list_sort_and_lookup_unit_macros.svh
// Assertion macros shared by the rank list checker.
// No dependencies.
`ifndef RANK_LIST_SORT_AND_LOOKUP_UNIT_MACROS_SVH
`define RANK_LIST_SORT_AND_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlsl check failed");

// Next-cycle implication, disabled during reset.
`define RLSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlsl check failed");

`endif

// File: rtl/rlsl_pkg.sv
// Package for the rank list sort and lookup unit: sizes, codes and state type.
// No dependencies.
`default_nettype none
package rlsl_pkg;
    localparam int MAX_RECORDS_DEF = 32;
    localparam int SCORE_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_SORT   = 2'd1,
        FN_LIST   = 2'd2,
        FN_SEARCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ACK,
        S_SORT_LD,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_LIST_RD,
        S_LIST_OUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_MISS
    } state_t;
endpackage
`default_nettype wire

// File: rtl/rank_list_sort_and_lookup_unit.sv
// Rank list store with stable descending sort, ranked listing and name search.
// Add stores the record unless full, then gives one result. Sort takes each record after the
// first through load, key, compare (once per move; at most n*(n-1)/2 moves) and put states,
// then gives an acknowledgement. List and search read, then output or compare, each record;
// one item at a time. Reset clears the record count; the record memory is not cleared.
`default_nettype none
module rank_list_sort_and_lookup_unit #(
    parameter int MAX_RECORDS = rlsl_pkg::MAX_RECORDS_DEF,
    parameter int SCORE_BITS  = rlsl_pkg::SCORE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] name_id,
    input  wire logic [15:0] score,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       rank,
    output logic [31:0]      out_name_id,
    output logic [15:0]      out_score,
    output logic [1:0]       status,
    output logic             last
);
    import rlsl_pkg::*;

    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int SB = SCORE_BITS;
    localparam int WW = 32 + SB;

    // Records are kept in reverse: list position k lives at address count-1-k.
    logic [WW-1:0] mem [MAX_RECORDS];

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] p_reg, p_next;
    logic [WW-1:0] key_reg, key_next;
    logic [1:0]    func_reg;
    logic [31:0]   nm_reg;
    logic [15:0]   sc_reg;
    logic [WW-1:0] rdata_reg;

    logic          ov_reg, ov_next;
    logic [6:0]    rank_reg, rank_next;
    logic [31:0]   oname_reg, oname_next;
    logic [15:0]   oscore_reg, oscore_next;
    logic [1:0]    ost_reg, ost_next;
    logic          olast_reg, olast_next;

    logic          load;
    logic          can_load;
    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [IW-1:0] rd_addr;

    logic signed [31:0] sc_ext;
    logic [SB-1:0]      sc_sb;
    logic signed [31:0] rd_ext;
    logic [15:0]        sc_back;
    logic [CW-1:0]      jm1;
    logic [CW-1:0]      jm2;
    logic [CW-1:0]      ip1;
    logic [CW-1:0]      cm1;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign can_load = !ov_reg || !out_stall;

    assign sc_ext  = 32'(signed'(sc_reg));
    assign sc_sb   = sc_ext[SB-1:0];
    assign sc_back = 16'(32'(signed'(sc_sb)));
    assign rd_ext  = 32'(signed'(rdata_reg[SB-1:0]));
    assign jm1     = j_reg - CW'(1);
    assign jm2     = j_reg - CW'(2);
    assign ip1     = i_reg + CW'(1);
    assign cm1     = cnt_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            nm_reg   <= name_id;
            sc_reg   <= score;
        end
        key_reg    <= key_next;
        rank_reg   <= rank_next;
        oname_reg  <= oname_next;
        oscore_reg <= oscore_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        key_next    = key_reg;
        load        = 1'b0;
        rank_next   = rank_reg;
        oname_next  = oname_reg;
        oscore_next = oscore_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_addr     = p_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        FN_SORT:
                        begin
                            i_next     = CW'(1);
                            state_next = (cnt_reg < CW'(2)) ? S_ACK : S_SORT_LD;
                        end
                        default:
                        begin
                            p_next = cm1[IW-1:0];
                            if (cnt_reg == '0)
                            begin
                                state_next = (func == FN_LIST) ? S_ACK : S_MISS;
                            end
                            else
                            begin
                                state_next = (func == FN_LIST) ? S_LIST_RD : S_SRCH_RD;
                            end
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    oname_next = nm_reg;
                    olast_next = 1'b1;
                    if (cnt_reg >= CW'(MAX_RECORDS))
                    begin
                        rank_next   = 7'd0;
                        oscore_next = sc_reg;
                        ost_next    = ST_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = cnt_reg[IW-1:0];
                        wr_data     = {nm_reg, sc_sb};
                        cnt_next    = cnt_reg + CW'(1);
                        rank_next   = 7'd1;
                        oscore_next = sc_back;
                        ost_next    = ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ACK:
            begin
                if (can_load)
                begin
                    load        = 1'b1;
                    rank_next   = 7'd0;
                    oname_next  = '0;
                    oscore_next = '0;
                    ost_next    = (func_reg == FN_LIST) ? ST_EMPTY : ST_OK;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SORT_LD:
            begin
                rd_addr    = i_reg[IW-1:0];
                state_next = S_SORT_KEY;
            end
            S_SORT_KEY:
            begin
                key_next   = rdata_reg;
                j_next     = i_reg;
                rd_addr    = IW'(i_reg - CW'(1));
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if ($signed(rdata_reg[SB-1:0]) > $signed(key_reg[SB-1:0]))
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[IW-1:0];
                    wr_data = rdata_reg;
                    j_next  = jm1;
                    rd_addr = jm2[IW-1:0];
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_SORT_PUT;
                    end
                end
                else
                begin
                    state_next = S_SORT_PUT;
                end
            end
            S_SORT_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IW-1:0];
                wr_data    = key_reg;
                i_next     = ip1;
                state_next = (ip1 >= cnt_reg) ? S_ACK : S_SORT_LD;
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (can_load)
                begin
                    load        = 1'b1;
                    rank_next   = 7'(cnt_reg - CW'(p_reg));
                    oname_next  = rdata_reg[WW-1:SB];
                    oscore_next = rd_ext[15:0];
                    ost_next    = ST_OK;
                    olast_next  = (p_reg == '0);
                    if (p_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg - IW'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rdata_reg[WW-1:SB] == nm_reg)
                begin
                    if (can_load)
                    begin
                        load        = 1'b1;
                        rank_next   = 7'(cnt_reg - CW'(p_reg));
                        oname_next  = nm_reg;
                        oscore_next = rd_ext[15:0];
                        ost_next    = ST_OK;
                        olast_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (p_reg == '0)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    p_next     = p_reg - IW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_MISS:
            begin
                if (can_load)
                begin
                    load        = 1'b1;
                    rank_next   = 7'd0;
                    oname_next  = nm_reg;
                    oscore_next = '0;
                    ost_next    = ST_NOTFOUND;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ov_next = load || (ov_reg && out_stall);
    end

    assign out_valid   = ov_reg;
    assign rank        = rank_reg;
    assign out_name_id = oname_reg;
    assign out_score   = oscore_reg;
    assign status      = ost_reg;
    assign last        = olast_reg;
endmodule
`default_nettype wire

// File: rtl/rlsl_checker.sv
// Port-level checker for the rank list sort and lookup unit, with its bind.
// Depends on rlsl_pkg and rank_list_sort_and_lookup_unit_macros.svh.
`default_nettype none
`include "rank_list_sort_and_lookup_unit_macros.svh"
module rlsl_checker #(
    parameter int MAX_RECORDS = rlsl_pkg::MAX_RECORDS_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [6:0]  rank,
    input wire logic [31:0] out_name_id,
    input wire logic [1:0]  status,
    input wire logic        last
);
    import rlsl_pkg::*;

    `RLSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_name_id) && $stable(rank))
    `RLSL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `RLSL_ASSERT_NOW(a_unranked, clk, rst_n, out_valid && status != ST_OK, rank == 7'd0 && last)
    `RLSL_ASSERT_NOW(a_rank_range, clk, rst_n, out_valid, rank <= 7'(MAX_RECORDS))
endmodule

bind rank_list_sort_and_lookup_unit rlsl_checker #(.MAX_RECORDS(MAX_RECORDS)) u_rlsl_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank(rank),
    .out_name_id(out_name_id),
    .status(status),
    .last(last)
);
`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the rank list sort and lookup unit: adds, sorts, listings and searches.
// A built-in predictor checks every result item; depends on rlsl_pkg and the unit.
module testbench;
    import rlsl_pkg::*;

    localparam int CAP = MAX_RECORDS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] name_id;
        logic [15:0] score;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  rank;
        logic [31:0] name_id;
        logic [15:0] score;
        logic [1:0]  status;
        logic        last;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] name_id;
    logic [15:0] score;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  rank;
    logic [31:0] out_name_id;
    logic [15:0] out_score;
    logic [1:0]  status;
    logic        last;

    cmd_t        pending_cmds[$];
    res_t        expected_results[$];
    logic [31:0] model_names[CAP];
    logic [15:0] model_scores[CAP];
    int          model_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_sender;
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          quiet_cycles;

    rank_list_sort_and_lookup_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .name_id(name_id), .score(score), .out_valid(out_valid),
        .out_stall(out_stall), .rank(rank), .out_name_id(out_name_id),
        .out_score(out_score), .status(status), .last(last)
    );

    function automatic res_t mk(logic [6:0] r, logic [31:0] n, logic [15:0] s,
                                status_t st, logic l);
        res_t x;
        x.rank = r;
        x.name_id = n;
        x.score = s;
        x.status = st;
        x.last = l;
        return x;
    endfunction

    task automatic predict_rank_list(input cmd_t c);
        logic [31:0] kn;
        logic [15:0] ks;
        int          j;
        bit          hit;
        case (func_t'(c.func))
            FN_ADD:
                if (model_count >= CAP)
                    expected_results.push_back(mk(0, c.name_id, c.score, ST_FULL, 1));
                else
                begin
                    for (int i = model_count; i > 0; i--)
                    begin
                        model_names[i] = model_names[i - 1];
                        model_scores[i] = model_scores[i - 1];
                    end
                    model_names[0] = c.name_id;
                    model_scores[0] = c.score;
                    model_count++;
                    expected_results.push_back(mk(1, c.name_id, c.score, ST_OK, 1));
                end
            FN_SORT:
            begin
                for (int i = 1; i < model_count; i++)
                begin
                    kn = model_names[i];
                    ks = model_scores[i];
                    j = i;
                    while (j > 0 && $signed(model_scores[j - 1]) < $signed(ks))
                    begin
                        model_names[j] = model_names[j - 1];
                        model_scores[j] = model_scores[j - 1];
                        j--;
                    end
                    model_names[j] = kn;
                    model_scores[j] = ks;
                end
                expected_results.push_back(mk(0, 0, 0, ST_OK, 1));
            end
            FN_LIST:
                if (model_count == 0)
                    expected_results.push_back(mk(0, 0, 0, ST_EMPTY, 1));
                else
                    for (int i = 0; i < model_count; i++)
                        expected_results.push_back(mk(i + 1, model_names[i], model_scores[i],
                                                      ST_OK, i + 1 == model_count));
            default:
            begin
                hit = 0;
                for (int i = 0; i < model_count && !hit; i++)
                    if (model_names[i] == c.name_id)
                    begin
                        expected_results.push_back(mk(i + 1, c.name_id, model_scores[i],
                                                      ST_OK, 1));
                        hit = 1;
                    end
                if (!hit)
                    expected_results.push_back(mk(0, c.name_id, 0, ST_NOTFOUND, 1));
            end
        endcase
    endtask

    function automatic cmd_t mkcmd(func_t f, logic [31:0] n, logic [15:0] s);
        cmd_t c;
        c.func = f;
        c.name_id = n;
        c.score = s;
        return c;
    endfunction

    function automatic logic [31:0] pick_name();
        if ($urandom_range(0, 3) != 0)
            return $urandom_range(0, 11);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_score();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4) - 2;
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            func <= 0;
            name_id <= 0;
            score <= 0;
            items_sent <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                predict_rank_list({func, name_id, score});
                items_sent <= items_sent + 1;
            end
            if (pending_cmds.size() != 0 && !hold_sender
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                in_valid <= 1;
                func <= c.func;
                name_id <= c.name_id;
                score <= c.score;
            end
            else
                in_valid <= 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            results_seen <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                res_t got;
                res_t want;
                got = {rank, out_name_id, out_score, status, last};
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired");
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        hold_sender = 1;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        hold_sender = 0;
    endtask

    initial
    begin
        func_t f;
        int    pick;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 0;
        mismatches = 0;
        model_count = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        pending_cmds.push_back(mkcmd(FN_LIST, 0, 0));
        pending_cmds.push_back(mkcmd(FN_SEARCH, 32'h1234, 0));
        pending_cmds.push_back(mkcmd(FN_SORT, 0, 0));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'h0, 16'h8000));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'hffffffff, 16'h7fff));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'h5, 16'h0));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'h6, 16'h7fff));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'h5, 16'hffff));
        pending_cmds.push_back(mkcmd(FN_LIST, 0, 0));
        pending_cmds.push_back(mkcmd(FN_SEARCH, 32'h5, 0));
        pending_cmds.push_back(mkcmd(FN_SORT, 0, 0));
        pending_cmds.push_back(mkcmd(FN_LIST, 0, 0));
        pending_cmds.push_back(mkcmd(FN_SEARCH, 32'hffffffff, 0));
        pending_cmds.push_back(mkcmd(FN_SEARCH, 32'h77, 0));
        for (int i = 0; i < 28; i++)
            pending_cmds.push_back(mkcmd(FN_ADD, i, pick_score()));
        pending_cmds.push_back(mkcmd(FN_ADD, 32'habcd, 16'h1234));
        pending_cmds.push_back(mkcmd(FN_SORT, 0, 0));
        pending_cmds.push_back(mkcmd(FN_LIST, 0, 0));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 62 : (ph == 3 ? 11 : 0);
            recv_stall_pct = (ph == 2) ? 62 : (ph == 3 ? 11 : 0);
            for (int n = 0; n < 90; n++)
            begin
                pick = $urandom_range(0, 99);
                if (model_count >= CAP - 2 && pick < 50 && ph != 3)
                    pick = 95;
                if (pick < 50)
                    f = FN_ADD;
                else if (pick < 65)
                    f = FN_SORT;
                else if (pick < 75)
                    f = FN_LIST;
                else
                    f = FN_SEARCH;
                pending_cmds.push_back(mkcmd(f, pick_name(), pick_score()));
            end
            if (ph == 1)
                pending_cmds.push_back(mkcmd(FN_LIST, 0, 0));
            drain();
        end
        $display("run covered %0d items and %0d results over four idle and stall mixes",
                 items_sent, results_seen);
        $display("including empty, full, sort, list and search hit and miss cases");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/rlsl_pkg.sv
rtl/rank_list_sort_and_lookup_unit.sv
rtl/rlsl_checker.sv
tb/sv/testbench.sv
